>>> design/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg: shared types and codes for the WebSocket frame deframer
// Parser phases, result kinds, error codes, message types and header opcodes.
// ----------------------------------------------------------------------------
package wsd_pkg;

   typedef enum logic [2:0] {
      PH_FIRST   = 3'd0,
      PH_SECOND  = 3'd1,
      PH_EXT     = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_HALT    = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_EMPTY   = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_FIN_CLEAR  = 2'd0,
      ERR_MASK_SET   = 2'd1,
      ERR_LEN_WIDE   = 2'd2,
      ERR_BAD_OPCODE = 2'd3
   } err_type;

   typedef enum logic [1:0] {
      MSG_TEXT   = 2'd0,
      MSG_BINARY = 2'd1,
      MSG_CLOSE  = 2'd2
   } msg_type;

   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   localparam logic [3:0] EXT_BYTES_SHORT = 4'd2;
   localparam logic [3:0] EXT_BYTES_LONG  = 4'd8;
   localparam logic [3:0] EXT_UPPER_BYTES = 4'd4;

endpackage

>>> design/websocket_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top: server-to-client WebSocket frame parser
// Parses frame headers from a byte stream and passes payload bytes out tagged.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle on the req_ stream while
// req_tready is high: every byte is parsed by one combinational state update
// (header byte check, extended length shift, payload down-count) and any
// result is loaded into the rsp_ output register on the byte transfer.
// req_tready stays high while the output register is empty or is being
// emptied in the same cycle, so a stalled consumer only holds the stream
// while a result is waiting. Header bytes produce no result unless the header
// completes a zero-length message (one empty-message result) or breaks the
// protocol (one error result). After an error the block swallows all further
// bytes without results until reset. Reset is synchronous, active high.
module websocket_frame_deframer_top (
   input  logic        clock,
   input  logic        reset,
   // request stream: tdata[7:0] rx_byte
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: [7:0] payload_byte, [39:8] message_length, [41:40] error_code,
   //        [47:42] zero
   output logic [47:0] rsp_tdata,
   // tuser: [1:0] result_kind, [3:2] message_type
   output logic [3:0]  rsp_tuser,
   // tlast: last_of_message
   output logic        rsp_tlast
);
   import wsd_pkg::*;

   // parser state
   phase_type   phase_ff, phase_in;
   logic [7:0]  held_ff, held_in;             // first header byte
   msg_type     mkind_ff, mkind_in;           // type of the current message
   logic [3:0]  ext_cnt_ff, ext_cnt_in;       // extended length bytes seen
   logic        long_ff, long_in;             // 64-bit length form
   logic [31:0] len_ff, len_in;               // decoded length
   logic [31:0] left_ff, left_in;             // payload bytes still to come

   // output register
   logic        rsp_valid_ff;
   kind_type    o_kind_ff, o_kind_in;
   logic [7:0]  o_data_ff, o_data_in;
   msg_type     o_mtype_ff, o_mtype_in;
   logic        o_last_ff, o_last_in;
   logic [31:0] o_len_ff, o_len_in;
   err_type     o_err_ff, o_err_in;

   logic        emit;
   logic        accept;
   logic        finish;       // header complete this byte
   logic [3:0]  ext_need;
   logic [3:0]  ext_cnt_inc;
   logic [3:0]  opcode;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign opcode     = held_ff[3:0];
   assign ext_need   = long_ff ? EXT_BYTES_LONG : EXT_BYTES_SHORT;
   assign ext_cnt_inc = ext_cnt_ff + 4'd1;

   always_comb begin
      phase_in   = phase_ff;
      held_in    = held_ff;
      mkind_in   = mkind_ff;
      ext_cnt_in = ext_cnt_ff;
      long_in    = long_ff;
      len_in     = len_ff;
      left_in    = left_ff;
      emit       = 1'b0;
      finish     = 1'b0;
      o_kind_in  = KIND_PAYLOAD;
      o_data_in  = 8'd0;
      o_mtype_in = MSG_TEXT;
      o_last_in  = 1'b0;
      o_len_in   = 32'd0;
      o_err_in   = ERR_FIN_CLEAR;

      case (phase_ff)
         PH_FIRST: begin
            if (!req_tdata[7]) begin
               phase_in  = PH_HALT;
               emit      = 1'b1;
               o_kind_in = KIND_ERROR;
               o_err_in  = ERR_FIN_CLEAR;
            end else begin
               held_in  = req_tdata;
               phase_in = PH_SECOND;
            end
         end
         PH_SECOND: begin
            if (req_tdata[7]) begin
               phase_in  = PH_HALT;
               emit      = 1'b1;
               o_kind_in = KIND_ERROR;
               o_err_in  = ERR_MASK_SET;
            end else begin
               ext_cnt_in = 4'd0;
               len_in     = 32'd0;
               long_in    = 1'b0;
               if (req_tdata[6:0] == LEN_EXT16) begin
                  phase_in = PH_EXT;
               end else if (req_tdata[6:0] == LEN_EXT64) begin
                  long_in  = 1'b1;
                  phase_in = PH_EXT;
               end else begin
                  len_in = {25'd0, req_tdata[6:0]};
                  finish = 1'b1;
               end
            end
         end
         PH_EXT: begin
            if (long_ff && (ext_cnt_ff < EXT_UPPER_BYTES) && (req_tdata != 8'd0)) begin
               // upper half of a 64-bit length must be zero
               phase_in  = PH_HALT;
               emit      = 1'b1;
               o_kind_in = KIND_ERROR;
               o_err_in  = ERR_LEN_WIDE;
            end else begin
               len_in     = {len_ff[23:0], req_tdata};
               ext_cnt_in = ext_cnt_inc;
               finish     = (ext_cnt_inc >= ext_need);
            end
         end
         PH_PAYLOAD: begin
            emit       = 1'b1;
            o_kind_in  = KIND_PAYLOAD;
            o_data_in  = req_tdata;
            o_mtype_in = mkind_ff;
            o_len_in   = len_ff;
            o_last_in  = (left_ff <= 32'd1);
            if (left_ff <= 32'd1) begin
               left_in  = 32'd0;
               phase_in = PH_FIRST;
            end else begin
               left_in = left_ff - 32'd1;
            end
         end
         default: begin
            // halted: bytes are swallowed
         end
      endcase

      if (finish) begin
         if ((opcode != OP_TEXT) && (opcode != OP_BINARY) && (opcode != OP_CLOSE)) begin
            phase_in  = PH_HALT;
            emit      = 1'b1;
            o_kind_in = KIND_ERROR;
            o_err_in  = ERR_BAD_OPCODE;
            o_len_in  = len_in;
         end else begin
            if (opcode == OP_TEXT) begin
               mkind_in = MSG_TEXT;
            end else if (opcode == OP_BINARY) begin
               mkind_in = MSG_BINARY;
            end else begin
               mkind_in = MSG_CLOSE;
            end
            if (len_in == 32'd0) begin
               // zero-length message: one empty-message result
               phase_in   = PH_FIRST;
               emit       = 1'b1;
               o_kind_in  = KIND_EMPTY;
               o_mtype_in = mkind_in;
               o_last_in  = 1'b1;
            end else begin
               left_in  = len_in;
               phase_in = PH_PAYLOAD;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_FIRST;
         held_ff    <= 8'd0;
         mkind_ff   <= MSG_TEXT;
         ext_cnt_ff <= 4'd0;
         long_ff    <= 1'b0;
         len_ff     <= 32'd0;
         left_ff    <= 32'd0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         held_ff    <= held_in;
         mkind_ff   <= mkind_in;
         ext_cnt_ff <= ext_cnt_in;
         long_ff    <= long_in;
         len_ff     <= len_in;
         left_ff    <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload, no reset
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         o_kind_ff  <= o_kind_in;
         o_data_ff  <= o_data_in;
         o_mtype_ff <= o_mtype_in;
         o_last_ff  <= o_last_in;
         o_len_ff   <= o_len_in;
         o_err_ff   <= o_err_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, o_err_ff, o_len_ff, o_data_ff};
   assign rsp_tuser  = {o_mtype_ff, o_kind_ff};
   assign rsp_tlast  = o_last_ff;

`ifndef SYNTH
   // halt is sticky
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HALT |=> phase_ff == PH_HALT)
      else $error("deframer left halt without reset");

   // every error result halts the parser
   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      accept && emit && o_kind_in == KIND_ERROR |=> phase_ff == PH_HALT)
      else $error("error result without halt");

   // a payload byte that is not last keeps the parser in payload
   a_payload_continues: assert property (@(posedge clock) disable iff (reset)
      accept && emit && o_kind_in == KIND_PAYLOAD && !o_last_in
      |=> phase_ff == PH_PAYLOAD)
      else $error("payload run ended early");

   // payload phase always has bytes outstanding
   a_left_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> left_ff != 32'd0)
      else $error("payload phase with zero bytes left");

   // a result is only loaded when the output register is free or draining
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !accept)
      else $error("byte accepted while result stalled");
`endif

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stream-level check of the WebSocket frame deframer
// Well-formed frames with random payloads go in one byte per transfer. A
// byte-level parser model predicts every result, and a monitor compares each
// response transfer with the oldest prediction. The run ends on one broken
// frame plus trailing bytes that the halted block has to swallow.
// ----------------------------------------------------------------------------
module tb_top;
   import wsd_pkg::*;

   localparam int ITEM_TARGET  = 1750;
   localparam int MAX_WAIT     = 11;
   localparam int STALL_LIMIT  = 400;   // cycles without any transfer
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_LIMIT = 10;

   // error_code and message_type read zero on results that do not use them
   localparam err_type NO_ERR = ERR_FIN_CLEAR;
   localparam msg_type NO_MSG = MSG_TEXT;

   typedef enum {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      msg_type     mtype;
      logic        last;
      logic [31:0] length;
      err_type     err;
   } deframe_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;            // [7:0] payload, [39:8] length, [41:40] error
   logic [3:0]  rsp_tuser;            // [1:0] result kind, [3:2] message type
   logic        rsp_tlast;            // last byte of message / empty message

   websocket_frame_deframer_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Stream bytes waiting to be driven; a set hold flag makes the sender wait
   // until every predicted result has been received before that byte.
   logic [7:0]         stream_bytes[$];
   logic               stream_hold[$];
   deframe_result_type awaited_results[$];

   logic        req_accepted = 1'b0;   // transfer seen at the last rising edge
   logic        rsp_accepted = 1'b0;
   logic [3:0]  send_gap     = 4'd0;
   logic [3:0]  recv_stall   = 4'd0;
   logic        send_calm    = 1'b0;   // calm: no idle cycles for a stretch
   logic        recv_calm    = 1'b0;
   int          error_count  = 0;
   int          idle_cycles  = 0;

   // Parser model state
   phase_type   parse_phase;
   logic [7:0]  first_hdr;
   msg_type     msg_kind;
   logic [3:0]  ext_count;
   logic        long_len;
   logic [31:0] len_accum;
   logic [31:0] remain;

   function automatic logic [3:0] draw_wait(input logic calm);
      return calm ? 4'd0 : 4'($urandom_range(0, MAX_WAIT));
   endfunction

   // ------------------------------------------------------------------------
   // Parser model
   // ------------------------------------------------------------------------
   task automatic push_result(input kind_type k, input logic [7:0] d, input msg_type m,
                              input logic l, input logic [31:0] len, input err_type e);
      deframe_result_type r;
      r.kind   = k;
      r.data   = d;
      r.mtype  = m;
      r.last   = l;
      r.length = len;
      r.err    = e;
      awaited_results.push_back(r);
   endtask

   // Any protocol error: one error result, then the block stays halted.
   task automatic halt_on(input err_type e, input logic [31:0] len);
      parse_phase = PH_HALT;
      push_result(KIND_ERROR, 8'h00, NO_MSG, 1'b0, len, e);
   endtask

   // Header complete: opcode check, then either an empty message or payload.
   task automatic close_header();
      logic op_ok;
      op_ok = 1'b1;
      case (first_hdr[3:0])
         OP_TEXT:   msg_kind = MSG_TEXT;
         OP_BINARY: msg_kind = MSG_BINARY;
         OP_CLOSE:  msg_kind = MSG_CLOSE;
         default:   op_ok = 1'b0;
      endcase
      if (!op_ok) begin
         halt_on(ERR_BAD_OPCODE, len_accum);
      end else if (len_accum == 32'd0) begin
         parse_phase = PH_FIRST;
         push_result(KIND_EMPTY, 8'h00, msg_kind, 1'b1, 32'd0, NO_ERR);
      end else begin
         remain      = len_accum;
         parse_phase = PH_PAYLOAD;
      end
   endtask

   task automatic deframe_byte(input logic [7:0] b);
      logic tail;
      case (parse_phase)
         PH_FIRST: begin
            if (!b[7]) begin
               halt_on(ERR_FIN_CLEAR, 32'd0);
            end else begin
               first_hdr   = b;
               parse_phase = PH_SECOND;
            end
         end
         PH_SECOND: begin
            if (b[7]) begin
               halt_on(ERR_MASK_SET, 32'd0);
            end else begin
               ext_count = 4'd0;
               len_accum = 32'd0;
               long_len  = (b[6:0] == LEN_EXT64);
               if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
                  parse_phase = PH_EXT;
               end else begin
                  len_accum = {25'd0, b[6:0]};
                  close_header();
               end
            end
         end
         PH_EXT: begin
            // 64-bit form: the four upper bytes must be zero
            if (long_len && ext_count < EXT_UPPER_BYTES && b != 8'h00) begin
               halt_on(ERR_LEN_WIDE, 32'd0);
            end else begin
               len_accum = {len_accum[23:0], b};
               ext_count = ext_count + 4'd1;
               if (ext_count >= (long_len ? EXT_BYTES_LONG : EXT_BYTES_SHORT))
                  close_header();
            end
         end
         PH_PAYLOAD: begin
            tail = (remain <= 32'd1);
            push_result(KIND_PAYLOAD, b, msg_kind, tail, len_accum, NO_ERR);
            if (tail) begin
               remain      = 32'd0;
               parse_phase = PH_FIRST;
            end else begin
               remain = remain - 32'd1;
            end
         end
         default: ;   // halted: bytes are swallowed
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Stimulus building
   // ------------------------------------------------------------------------
   task automatic queue_byte(input logic [7:0] b, input logic hold);
      stream_bytes.push_back(b);
      stream_hold.push_back(hold);
   endtask

   // RSV bits are random; the block ignores them.
   task automatic add_header(input logic [3:0] op, input logic [31:0] len,
                             input len_form_type form, input logic hold);
      queue_byte({1'b1, 3'($urandom_range(0, 7)), op}, hold);
      case (form)
         FORM_SHORT: queue_byte({1'b0, len[6:0]}, 1'b0);
         FORM_EXT16: begin
            queue_byte({1'b0, LEN_EXT16}, 1'b0);
            queue_byte(len[15:8], 1'b0);
            queue_byte(len[7:0], 1'b0);
         end
         default: begin
            queue_byte({1'b0, LEN_EXT64}, 1'b0);
            repeat (EXT_UPPER_BYTES) queue_byte(8'h00, 1'b0);
            queue_byte(len[31:24], 1'b0);
            queue_byte(len[23:16], 1'b0);
            queue_byte(len[15:8], 1'b0);
            queue_byte(len[7:0], 1'b0);
         end
      endcase
   endtask

   task automatic add_frame(input logic [3:0] op, input logic [31:0] len,
                            input len_form_type form, input logic hold);
      add_header(op, len, form, hold);
      repeat (len) queue_byte(8'($urandom_range(0, 255)), 1'b0);
   endtask

   function automatic logic [3:0] pick_opcode();
      case ($urandom_range(0, 2))
         0:       return OP_TEXT;
         1:       return OP_BINARY;
         default: return OP_CLOSE;
      endcase
   endfunction

   // One random well-formed frame; lengths stay short, with some around the
   // 125/126 boundary and a few up to a few hundred bytes.
   task automatic add_random_frame(input logic hold);
      int unsigned  len;
      int unsigned  pick;
      len_form_type form;
      pick = $urandom_range(0, 99);
      if (pick < 72)      len = $urandom_range(0, 20);
      else if (pick < 84) len = $urandom_range(121, 130);
      else                len = $urandom_range(21, 300);
      if (len <= 125 && $urandom_range(0, 1) == 0) form = FORM_SHORT;
      else if ($urandom_range(0, 1) == 0)          form = FORM_EXT16;
      else                                         form = FORM_EXT64;
      add_frame(pick_opcode(), len, form, hold);
   endtask

   // Any error halts the block until reset, and reset happens only once, so
   // the run closes with exactly one broken frame of a randomly chosen kind.
   task automatic add_broken_frame(input err_type e);
      logic [3:0]  op;
      logic [31:0] len;
      case (e)
         ERR_FIN_CLEAR: queue_byte({1'b0, 7'($urandom_range(0, 127))}, 1'b1);
         ERR_MASK_SET: begin
            queue_byte({1'b1, 3'($urandom_range(0, 7)), pick_opcode()}, 1'b1);
            queue_byte({1'b1, 7'($urandom_range(0, 127))}, 1'b0);
         end
         ERR_LEN_WIDE: begin
            queue_byte({1'b1, 3'($urandom_range(0, 7)), pick_opcode()}, 1'b1);
            queue_byte({1'b0, LEN_EXT64}, 1'b0);
            repeat ($urandom_range(0, EXT_UPPER_BYTES - 1)) queue_byte(8'h00, 1'b0);
            queue_byte(8'($urandom_range(1, 255)), 1'b0);
         end
         default: begin
            do op = 4'($urandom_range(0, 15));
            while (op == OP_TEXT || op == OP_BINARY || op == OP_CLOSE);
            // reported length reaches all 32 bits here
            len = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : 32'($urandom);
            add_header(op, len, FORM_EXT64, 1'b1);
         end
      endcase
      // halted: these must produce nothing
      repeat (12) queue_byte(8'($urandom_range(0, 255)), 1'b0);
   endtask

   // ------------------------------------------------------------------------
   // Sender: one byte per transfer, random gap after each one
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= draw_wait(1'b0);
      end else if (!req_tvalid || req_accepted) begin
         if (send_gap != 4'd0) begin
            req_tvalid <= 1'b0;
            send_gap   <= send_gap - 4'd1;
         end else if (stream_bytes.size() != 0 &&
                      !(stream_hold[0] && awaited_results.size() != 0)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= stream_bytes.pop_front();
            void'(stream_hold.pop_front());
            if ($urandom_range(0, 39) == 0) send_calm <= !send_calm;
            send_gap   <= draw_wait(send_calm);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: tready drops for a random stall after each response transfer
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : receiver
      logic [3:0] w;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall <= 4'd0;
      end else if (rsp_accepted) begin
         w = draw_wait(recv_calm);
         if ($urandom_range(0, 39) == 0) recv_calm <= !recv_calm;
         recv_stall <= w;
         rsp_tready <= (w == 4'd0);
      end else if (recv_stall != 4'd0) begin
         recv_stall <= recv_stall - 4'd1;
         rsp_tready <= (recv_stall == 4'd1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: check responses, feed accepted bytes to the model, watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      deframe_result_type seen;
      deframe_result_type want;
      if (reset) begin
         req_accepted <= 1'b0;
         rsp_accepted <= 1'b0;
         parse_phase  = PH_FIRST;
         first_hdr    = 8'h00;
         msg_kind     = MSG_TEXT;
         ext_count    = 4'd0;
         long_len     = 1'b0;
         len_accum    = 32'd0;
         remain       = 32'd0;
         idle_cycles  = 0;
      end else begin
         req_accepted <= req_tvalid && req_tready;
         rsp_accepted <= rsp_tvalid && rsp_tready;

         // check before predicting: a result never belongs to the byte
         // accepted at the same edge
         if (rsp_tvalid && rsp_tready) begin
            seen.kind   = kind_type'(rsp_tuser[1:0]);
            seen.mtype  = msg_type'(rsp_tuser[3:2]);
            seen.data   = rsp_tdata[7:0];
            seen.length = rsp_tdata[39:8];
            seen.err    = err_type'(rsp_tdata[41:40]);
            seen.last   = rsp_tlast;
            if (awaited_results.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("unexpected result: kind %0d data %h type %0d last %0d len %h err %0d",
                           seen.kind, seen.data, seen.mtype, seen.last, seen.length, seen.err);
            end else begin
               want = awaited_results.pop_front();
               if (seen !== want) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT) begin
                     $display("mismatch exp: kind %0d data %h type %0d last %0d len %h err %0d",
                              want.kind, want.data, want.mtype, want.last, want.length,
                              want.err);
                     $display("         act: kind %0d data %h type %0d last %0d len %h err %0d",
                              seen.kind, seen.data, seen.mtype, seen.last, seen.length,
                              seen.err);
                  end
               end
            end
         end

         if (req_tvalid && req_tready) deframe_byte(req_tdata);

         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("tb_top: FAIL");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      // Directed: byte extremes, all three message types, empty messages in the
      // short and 16-bit forms, non-minimal 16- and 64-bit length encodings.
      add_header(OP_TEXT, 32'd2, FORM_SHORT, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
      add_frame(OP_BINARY, 32'd0, FORM_SHORT, 1'b0);
      add_frame(OP_CLOSE, 32'd1, FORM_SHORT, 1'b0);
      add_frame(OP_TEXT, 32'd0, FORM_EXT16, 1'b0);
      add_frame(OP_BINARY, 32'd3, FORM_EXT16, 1'b0);
      add_frame(OP_CLOSE, 32'd2, FORM_EXT64, 1'b0);

      // Random frames; the first one waits for the block to drain completely,
      // later ones now and then.
      add_random_frame(1'b1);
      while (stream_bytes.size() < ITEM_TARGET)
         add_random_frame($urandom_range(0, 59) == 0);

      add_broken_frame(err_type'($urandom_range(0, 3)));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (stream_bytes.size() != 0 || req_tvalid || awaited_results.size() != 0)
         @(posedge clock);
      // any stray result after the last expected one is caught here
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

>>> sim.f
design/wsd_pkg.sv
design/websocket_frame_deframer_top.sv
tb/tb_top.sv
